### rtl/pfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// Field widths, beat layout and status codes of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // request fields
  localparam int PID_W    = 4;
  localparam int CNT_IN_W = 4;
  localparam int IN_TDATA_W = 8;

  // result fields
  localparam int STATUS_W = 2;
  localparam int PAGE_W   = 3;
  localparam int FRAME_W  = 4;
  localparam int FREED_W  = 4;
  localparam int LEFT_W   = 5;
  localparam int OUT_TDATA_W = 16;

  // request kind
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FRAMES = 2'd1,
    ST_SLOT_BUSY = 2'd2
  } status_t;

endpackage

### rtl/pfa_page_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_map_ram
// Single-port-write, single-port-read page table ram with registered read.
// ----------------------------------------------------------------------------
module pfa_map_ram #(
  parameter int ADDR_W = 7,
  parameter int DATA_W = 4,
  parameter int DEPTH  = 128
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/page_frame_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator
// First-fit physical frame allocator with a page table per process slot.
// One request at a time. Allocate: the slot number is folded into range,
// the held count is read, then the free map is scanned first-fit.
// Free: each held page is read from the page table and its frame returned.
// Results wait in an output register; a stalled sink stalls the sequencer.
// Reset (synchronous, active low): all frames free, all slots empty.
// ----------------------------------------------------------------------------
module page_frame_allocator
  import pfa_pkg::*;
#(
  parameter int NUM_FRAMES        = 16,
  parameter int NUM_PROCESSES     = 16,
  parameter int PAGES_PER_PROCESS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // process_id [3:0], page_count [7:4]
  input  logic [0:0]             in_tuser,   // operation [0]
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // page_index [2:0], frame_number [6:3],
                                             // freed_count [10:7], free_left [15:11]
  output logic [STATUS_W-1:0]    out_tuser,  // status [1:0]
  output logic                   out_tlast   // last
);

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int TW = $clog2(NUM_FRAMES + 1);
  localparam int SW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
  localparam int PW = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
  localparam int CW = $clog2(PAGES_PER_PROCESS + 1);
  localparam int PT_AW = SW + PW;
  localparam int PT_DEPTH = NUM_PROCESSES * (2 ** PW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,
    S_HELD,
    S_SCAN,
    S_FREE_RD,
    S_FREE_UPD
  } state_t;

  state_t               state_r;
  logic                 op_r;
  logic [PID_W-1:0]     pid_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        n_r;
  logic [CW-1:0]        p_r;
  logic [FW-1:0]        ptr_r;
  logic [NUM_FRAMES-1:0] free_map_r;
  logic [TW-1:0]        total_r;
  logic [NUM_PROCESSES-1:0] held_vld_r;
  logic [CW-1:0]        held_rd_r;
  logic [CW-1:0]        held_mem [NUM_PROCESSES];

  // output register
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [PAGE_W-1:0]    out_page_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic [FREED_W-1:0]   out_freed_r;
  logic [LEFT_W-1:0]    out_left_r;
  logic                 out_last_r;

  logic [SW-1:0]        slot_c;
  logic [CW-1:0]        cnt_sat_c;
  logic [CW-1:0]        held_c;
  logic                 out_free_c;
  logic                 scan_hit_c;
  logic                 alloc_last_c;
  logic                 free_last_c;
  logic                 alloc_err_c;
  logic                 out_load_c;
  logic                 ret_c;
  logic [TW-1:0]        total_nxt;
  logic                 page_we_c;
  logic                 held_we_c;
  logic [PT_AW-1:0]     pt_addr_c;
  logic [FW-1:0]        pt_rd_data;

  // request decode and per-state conditions
  always_comb begin
    slot_c     = SW'(pid_r);
    cnt_sat_c  = (32'(in_tdata[7:4]) > PAGES_PER_PROCESS) ? CW'(PAGES_PER_PROCESS)
                                                          : CW'(in_tdata[7:4]);
    held_c     = held_vld_r[slot_c] ? held_rd_r : '0;
    out_free_c = !out_valid_r || out_tready;
    scan_hit_c = free_map_r[ptr_r];
    alloc_last_c = ((p_r + 1'b1) == cnt_r);
    free_last_c  = ((p_r + 1'b1) == n_r);
    alloc_err_c  = (held_c != '0) || (32'(cnt_r) > 32'(total_r)) || (cnt_r == '0);
    // a result beat is loaded this cycle
    out_load_c   = out_free_c &&
                   (((state_r == S_HELD) &&
                     ((op_r == OP_FREE) ? (held_c == '0) : alloc_err_c)) ||
                    ((state_r == S_SCAN) && scan_hit_c) ||
                    ((state_r == S_FREE_UPD) && free_last_c));
    ret_c      = (32'(pt_rd_data) < NUM_FRAMES) && !free_map_r[pt_rd_data];
    total_nxt  = total_r + TW'(ret_c);
    page_we_c  = (state_r == S_SCAN) && scan_hit_c && out_free_c;
    held_we_c  = page_we_c && alloc_last_c;
    pt_addr_c  = {slot_c, p_r[PW-1:0]};
  end

  // page table: frame per (slot, page)
  pfa_map_ram #(
    .ADDR_W (PT_AW),
    .DATA_W (FW),
    .DEPTH  (PT_DEPTH)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (page_we_c),
    .wr_addr (pt_addr_c),
    .wr_data (ptr_r),
    .rd_addr (pt_addr_c),
    .rd_data (pt_rd_data)
  );

  // held page count per slot, registered read
  always_ff @(posedge clk) begin
    if (held_we_c) begin
      held_mem[slot_c] <= cnt_r;
    end
    held_rd_r <= held_mem[slot_c];
  end

  // sequencer with free map, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_map_r  <= '1;
      total_r     <= TW'(NUM_FRAMES);
      held_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load_c || (out_valid_r && !out_tready);
      unique case (state_r)
        // take a request
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser[0];
            pid_r   <= in_tdata[3:0];
            cnt_r   <= cnt_sat_c;
            state_r <= S_WRAP;
          end
        end
        // fold slot number into range, one subtract a cycle
        S_WRAP: begin
          if (32'(pid_r) >= NUM_PROCESSES) begin
            pid_r <= pid_r - PID_W'(NUM_PROCESSES);
          end else begin
            state_r <= S_HELD;
          end
        end
        // held count is back: decide what the request does
        S_HELD: begin
          if (op_r == OP_FREE) begin
            if (held_c == '0) begin
              if (out_free_c) begin
                out_status_r <= ST_OK;
                out_page_r   <= '0;
                out_frame_r  <= '0;
                out_freed_r  <= '0;
                out_left_r   <= LEFT_W'(total_r);
                out_last_r   <= 1'b1;
                state_r      <= S_IDLE;
              end
            end else begin
              n_r                <= held_c;
              p_r                <= '0;
              held_vld_r[slot_c] <= 1'b0;
              state_r            <= S_FREE_RD;
            end
          end else if (alloc_err_c) begin
            if (out_free_c) begin
              out_status_r <= (held_c != '0) ? ST_SLOT_BUSY :
                              (32'(cnt_r) > 32'(total_r)) ? ST_NO_FRAMES : ST_OK;
              out_page_r   <= '0;
              out_frame_r  <= '0;
              out_freed_r  <= '0;
              out_left_r   <= LEFT_W'(total_r);
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else begin
            p_r     <= '0;
            ptr_r   <= '0;
            state_r <= S_SCAN;
          end
        end
        // first-fit scan, one frame a cycle; a hit waits while the result register is full
        S_SCAN: begin
          if (!scan_hit_c) begin
            ptr_r <= ptr_r + 1'b1;
          end else if (out_free_c) begin
            free_map_r[ptr_r] <= 1'b0;
            total_r           <= total_r - 1'b1;
            out_status_r      <= ST_OK;
            out_page_r        <= PAGE_W'(p_r);
            out_frame_r       <= FRAME_W'(ptr_r);
            out_freed_r       <= '0;
            out_left_r        <= LEFT_W'(total_r - 1'b1);
            out_last_r        <= alloc_last_c;
            p_r               <= p_r + 1'b1;
            ptr_r             <= ptr_r + 1'b1;
            if (alloc_last_c) begin
              held_vld_r[slot_c] <= 1'b1;
              state_r            <= S_IDLE;
            end
          end
        end
        // page table read in flight
        S_FREE_RD: begin
          state_r <= S_FREE_UPD;
        end
        // return one frame to the free map
        S_FREE_UPD: begin
          if (!free_last_c || out_free_c) begin
            if (ret_c) begin
              free_map_r[pt_rd_data] <= 1'b1;
            end
            total_r <= total_nxt;
            p_r     <= p_r + 1'b1;
            if (free_last_c) begin
              out_status_r <= ST_OK;
              out_page_r   <= '0;
              out_frame_r  <= '0;
              out_freed_r  <= FREED_W'(n_r);
              out_left_r   <= LEFT_W'(total_nxt);
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end else begin
              state_r <= S_FREE_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ports
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_left_r, out_freed_r, out_frame_r, out_page_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

### bench/page_frame_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_tb
// Self-checking bench for the first-fit page frame allocator. A directed
// pass covers slot busy, frame exhaustion, zero and oversized counts, double
// free and frame reuse. Random request traffic, a long sink hold-off and a
// gap-free tail follow. A local copy of the free map and page tables predicts
// every result beat, and each beat is checked field by field in order.
// ----------------------------------------------------------------------------
module page_frame_allocator_tb;
  import pfa_pkg::*;

  localparam int FRAMES     = 16;
  localparam int SLOTS      = 16;
  localparam int SLOT_PAGES = 8;

  typedef struct packed {
    status_t             status;
    logic [PAGE_W-1:0]   page_index;
    logic [FRAME_W-1:0]  frame_number;
    logic [FREED_W-1:0]  freed_count;
    logic [LEFT_W-1:0]   free_left;
    logic                is_last;
  } frame_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // process_id [3:0], page_count [7:4]
  logic [0:0]             in_tuser   = '0;   // operation [0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // page_index [2:0], frame_number [6:3],
                                             // freed_count [10:7], free_left [15:11]
  logic [STATUS_W-1:0]    out_tuser;         // status [1:0]
  logic                   out_tlast;

  // shadow allocator state
  logic [FRAMES-1:0]  frame_free;
  logic [FRAME_W-1:0] shadow_map [SLOTS][SLOT_PAGES];
  int                 slot_pages [SLOTS];
  int                 free_count;

  frame_result_t frame_results_due [$];
  int            mismatches   = 0;
  bit            sender_gaps  = 1'b0;
  bit            sink_gaps    = 1'b0;
  int            hold_request = 0;
  int            hold_left    = 0;
  int            stall_left   = 0;

  page_frame_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // watchdog
  initial begin
    #3000000;
    $display("page_frame_allocator_tb failed");
    $finish;
  end

  function automatic frame_result_t make_result(status_t st, int page, int frame, int freed,
                                                int left, bit fin);
    frame_result_t r;
    r.status       = st;
    r.page_index   = page[PAGE_W-1:0];
    r.frame_number = frame[FRAME_W-1:0];
    r.freed_count  = freed[FREED_W-1:0];
    r.free_left    = left[LEFT_W-1:0];
    r.is_last      = fin;
    return r;
  endfunction

  // work out the result beats of one accepted request and update the shadow state
  task automatic predict_frame_map(input logic op, input logic [PID_W-1:0] pid,
                                   input logic [CNT_IN_W-1:0] cnt_in);
    int want;
    int held;
    int f;
    held = slot_pages[pid];
    want = (cnt_in > SLOT_PAGES) ? SLOT_PAGES : int'(cnt_in);
    if (op == OP_FREE) begin
      for (int p = 0; p < held; p++) begin
        f = int'(shadow_map[pid][p]);
        if (!frame_free[f]) begin
          frame_free[f] = 1'b1;
          free_count++;
        end
      end
      slot_pages[pid] = 0;
      frame_results_due.push_back(make_result(ST_OK, 0, 0, held, free_count, 1'b1));
    end else if (held != 0) begin
      frame_results_due.push_back(make_result(ST_SLOT_BUSY, 0, 0, 0, free_count, 1'b1));
    end else if (want > free_count) begin
      frame_results_due.push_back(make_result(ST_NO_FRAMES, 0, 0, 0, free_count, 1'b1));
    end else if (want == 0) begin
      frame_results_due.push_back(make_result(ST_OK, 0, 0, 0, free_count, 1'b1));
    end else begin
      for (int p = 0; p < want; p++) begin
        // first fit: lowest free frame
        f = 0;
        while (!frame_free[f]) f++;
        frame_free[f] = 1'b0;
        free_count--;
        shadow_map[pid][p] = f[FRAME_W-1:0];
        frame_results_due.push_back(make_result(ST_OK, p, f, 0, free_count, p + 1 == want));
      end
      slot_pages[pid] = want;
    end
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  // request and result monitor, sampled at the rising edge
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (!rst_n) begin
      frame_free = '1;
      free_count = FRAMES;
      foreach (slot_pages[s]) slot_pages[s] = 0;
    end else begin
      if (in_tvalid && in_tready)
        predict_frame_map(in_tuser[0], in_tdata[PID_W-1:0], in_tdata[IN_TDATA_W-1:PID_W]);
      if (out_tvalid && out_tready) begin
        if (frame_results_due.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, got tdata %h tuser %0d",
                   $time, out_tdata, out_tuser);
          mismatches++;
        end else begin
          exp_r = frame_results_due.pop_front();
          check_field("status", exp_r.status, out_tuser);
          check_field("page_index", exp_r.page_index, out_tdata[2:0]);
          check_field("frame_number", exp_r.frame_number, out_tdata[6:3]);
          check_field("freed_count", exp_r.freed_count, out_tdata[10:7]);
          check_field("free_left", exp_r.free_left, out_tdata[15:11]);
          check_field("last", exp_r.is_last, out_tlast);
        end
      end
    end
  end

  // sink ready: long hold-off on request, random stall bursts otherwise
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
      stall_left = int'($urandom_range(1, 19)) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // drive one request beat; called at a falling edge, returns at a falling edge
  task automatic send_request(input logic op, input logic [PID_W-1:0] pid,
                              input logic [CNT_IN_W-1:0] cnt);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);
      in_tuser  <= 1'($urandom);
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cnt, pid};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // random request, biased toward sequences that succeed
  task automatic send_random_request();
    logic                op;
    logic [PID_W-1:0]    pid;
    logic [CNT_IN_W-1:0] cnt;
    int                  roll;
    int                  tries;
    op    = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
    pid   = PID_W'($urandom_range(0, SLOTS - 1));
    tries = 0;
    // frees mostly hit loaded slots, allocations mostly empty ones
    while (tries < 4 && ((op == OP_FREE) == (slot_pages[pid] == 0))) begin
      pid = PID_W'($urandom_range(0, SLOTS - 1));
      tries++;
    end
    roll = $urandom_range(0, 99);
    if (roll < 8)       cnt = '0;
    else if (roll < 18) cnt = CNT_IN_W'($urandom_range(SLOT_PAGES + 1, 15));
    else if (roll < 60) cnt = CNT_IN_W'($urandom_range(1, 3));
    else                cnt = CNT_IN_W'($urandom_range(4, SLOT_PAGES));
    send_request(op, pid, cnt);
  endtask

  task automatic test_directed_cases();
    send_request(OP_ALLOC, 4'd0, 4'd1);
    send_request(OP_ALLOC, 4'd1, 4'd8);            // largest legal count
    send_request(OP_ALLOC, 4'd0, 4'd3);            // slot already holds pages
    send_request(OP_ALLOC, 4'd2, 4'd0);            // zero count
    send_request(OP_ALLOC, 4'd3, 4'd15);           // oversized, clipped, too few frames
    send_request(OP_ALLOC, 4'd3, 4'd7);            // takes the last free frames
    send_request(OP_ALLOC, 4'd4, 4'd1);            // nothing left
    send_request(OP_ALLOC, 4'd0, 4'd15);           // busy wins over no frames
    send_request(OP_FREE, 4'd1, CNT_IN_W'($urandom));
    send_request(OP_FREE, 4'd1, CNT_IN_W'($urandom)); // double free
    send_request(OP_FREE, 4'd15, 4'd0);            // empty slot
    send_request(OP_ALLOC, 4'd15, 4'd9);           // oversized, fills the hole
    send_request(OP_FREE, 4'd0, 4'd15);
    send_request(OP_ALLOC, 4'd10, 4'd1);           // reuses frame zero
    send_request(OP_ALLOC, 4'd2, 4'd0);            // zero count with no frames free
    send_request(OP_FREE, 4'd3, 4'd5);
    send_request(OP_FREE, 4'd15, 4'd10);
    send_request(OP_FREE, 4'd10, 4'd1);
    send_request(OP_ALLOC, 4'd6, 4'd8);
    send_request(OP_ALLOC, 4'd7, 4'd8);            // every frame taken
    send_request(OP_FREE, 4'd6, 4'd0);
    send_request(OP_FREE, 4'd7, 4'd0);
  endtask

  task automatic test_random_requests(input int count);
    repeat (count) send_random_request();
  endtask

  // sink holds off while requests keep coming, so the input stalls
  task automatic test_sink_backpressure();
    sender_gaps  = 1'b0;
    hold_request = 300;
    repeat (10) send_random_request();
    sender_gaps  = 1'b1;
  endtask

  task automatic test_gapless_tail();
    sender_gaps = 1'b0;
    sink_gaps   = 1'b0;
    repeat (20) send_random_request();
  endtask

  initial begin
    int guard;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    sender_gaps = 1'b1;
    sink_gaps   = 1'b1;

    test_directed_cases();
    test_random_requests(50);
    test_sink_backpressure();
    test_gapless_tail();
    in_tvalid <= 1'b0;

    // drain, then let any stray beat show up
    guard = 0;
    while (frame_results_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);

    if (frame_results_due.size() != 0)
      $display("%0t ns: results missing, expected %0d more, got 0",
               $time, frame_results_due.size());
    if (mismatches == 0 && frame_results_due.size() == 0) begin
      $display("page_frame_allocator_tb passed");
    end else begin
      $display("page_frame_allocator_tb failed");
    end
    $finish;
  end

endmodule
